### hw/rtl/gerpw_pkg.sv
// gerpw_pkg: widths, register indexes, beat struct and the gamma threshold table
// builder for the gamma encode rgba pixel writer
// depends on nothing
`default_nettype none

package gerpw_pkg;

    localparam int PIX_W      = 12;
    localparam int DIM_W      = 13;
    localparam int VAL_W      = 16;
    localparam int CODE_W     = 8;
    localparam int ADDR_W     = 26;
    localparam int CFG_IDX_W  = 8;
    localparam int PROD_W     = DIM_W + DIM_W;

    localparam int MAX_DIM_DEF       = 4096;
    localparam int FRACTION_BITS_DEF = 15;
    localparam int FRAC_BITS_MAX     = 20;

    localparam int CODE_MAX    = (1 << CODE_W) - 1;
    localparam int THR_W       = FRAC_BITS_MAX + 1;
    localparam int BIG_W       = 200;
    localparam int LANE_STAGES = CODE_W;
    localparam int ADDR_STAGES = 3;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = CFG_IDX_W'(0),
        REG_FRAME_HEIGHT = CFG_IDX_W'(1)
    } t_reg_idx;

    typedef struct packed {
        logic              in_bounds;
        logic [ADDR_W-1:0] byte_address;
    } t_addr_beat;

    typedef logic [CODE_MAX:0][THR_W-1:0] t_thr_table;

    // entry c is the smallest value v with v^5 * 255^11 >= c^11 * 2^(5*frac_bits)
    function automatic t_thr_table gamma_table(input int frac_bits);
        t_thr_table        tbl;
        logic [BIG_W-1:0]  k255;
        logic [BIG_W-1:0]  rhs;
        logic [BIG_W-1:0]  lhs;
        logic [THR_W:0]    lo;
        logic [THR_W:0]    hi;
        logic [THR_W:0]    mid;
        tbl  = '0;
        k255 = BIG_W'(1);
        for (int i = 0; i < 11; i++) begin
            k255 = k255 * BIG_W'(CODE_MAX);
        end
        for (int c = 1; c <= CODE_MAX; c++) begin
            rhs = BIG_W'(1);
            for (int i = 0; i < 11; i++) begin
                rhs = rhs * BIG_W'(c);
            end
            rhs = rhs << (5 * frac_bits);
            lo  = '0;
            hi  = (THR_W + 1)'(1) << frac_bits;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                lhs = BIG_W'(mid);
                for (int i = 0; i < 4; i++) begin
                    lhs = lhs * BIG_W'(mid);
                end
                lhs = lhs * k255;
                if (lhs >= rhs) begin
                    hi = mid;
                end else begin
                    lo = mid + 1'b1;
                end
            end
            tbl[c] = THR_W'(lo);
        end
        return tbl;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/gerpw_lane.sv
// gerpw_lane: one channel of gamma encoding, a code search pipelined one bit per stage
// depends on gerpw_pkg for widths and the threshold table
`default_nettype none

module gerpw_lane #(
    parameter int FRACTION_BITS = gerpw_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic [gerpw_pkg::VAL_W-1:0]  i_value,
    output logic      [gerpw_pkg::CODE_W-1:0] o_code
);
    import gerpw_pkg::*;

    localparam t_thr_table THR = gamma_table(FRACTION_BITS);

    logic [VAL_W-1:0]  r_val  [LANE_STAGES];
    logic [CODE_W-1:0] r_code [LANE_STAGES];

    for (genvar k = 0; k < LANE_STAGES; k++) begin : g_stage
        logic [VAL_W-1:0]  val_in;
        logic [CODE_W-1:0] code_in;
        logic [CODE_W-1:0] trial;
        logic [CODE_W-1:0] n_code;

        if (k == 0) begin : g_first
            assign val_in  = i_value;
            assign code_in = '0;
        end else begin : g_next
            assign val_in  = r_val[k-1];
            assign code_in = r_code[k-1];
        end

        always_comb begin
            trial  = code_in | (CODE_W'(1) << (LANE_STAGES - 1 - k));
            n_code = (THR_W'(val_in) >= THR[trial]) ? trial : code_in;
        end

        always_ff @(posedge i_clk) begin
            r_val[k]  <= val_in;
            r_code[k] <= n_code;
        end
    end

    assign o_code = r_code[LANE_STAGES-1];

endmodule

`default_nettype wire

### hw/rtl/gerpw_addr.sv
// gerpw_addr: bounds check, row flip and byte address, padded to the lane latency
// depends on gerpw_pkg for widths and the address beat struct
`default_nettype none

module gerpw_addr (
    input  wire logic                        i_clk,
    input  wire logic [gerpw_pkg::PIX_W-1:0] i_pixel_column,
    input  wire logic [gerpw_pkg::PIX_W-1:0] i_pixel_row,
    input  wire logic [gerpw_pkg::DIM_W-1:0] i_width,
    input  wire logic [gerpw_pkg::DIM_W-1:0] i_height,
    output gerpw_pkg::t_addr_beat            o_beat
);
    import gerpw_pkg::*;

    localparam int DLY = LANE_STAGES - ADDR_STAGES;

    logic              r_inb1;
    logic [DIM_W-1:0]  r_flip;
    logic [PIX_W-1:0]  r_col1;
    logic [DIM_W-1:0]  r_w;
    logic              r_inb2;
    logic [PROD_W-1:0] r_prod;
    logic [PIX_W-1:0]  r_col2;
    t_addr_beat        r_beat;
    t_addr_beat        r_dly [DLY];

    always_ff @(posedge i_clk) begin
        r_inb1 <= ({1'b0, i_pixel_column} < i_width) && ({1'b0, i_pixel_row} < i_height);
        r_flip <= i_height - DIM_W'(1) - {1'b0, i_pixel_row};
        r_col1 <= i_pixel_column;
        r_w    <= i_width;

        r_inb2 <= r_inb1;
        r_prod <= PROD_W'(r_flip) * PROD_W'(r_w);
        r_col2 <= r_col1;

        r_beat.in_bounds    <= r_inb2;
        r_beat.byte_address <= ADDR_W'({ADDR_W'(r_prod) + ADDR_W'(r_col2), 2'b00});

        r_dly[0] <= r_beat;
        for (int i = 1; i < DLY; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    assign o_beat = r_dly[DLY-1];

endmodule

`default_nettype wire

### hw/rtl/gamma_encode_rgba_pixel_writer.sv
// gamma_encode_rgba_pixel_writer: top level, frame size registers, three encode lanes,
// address unit and the merging output register
// depends on gerpw_pkg, gerpw_lane and gerpw_addr
//
// usage
//   pixel channel: a pixel beat is taken at every clock edge with start high; busy
//   stays low, so one pixel per cycle is accepted with no gaps
//   result channel: o_valid marks a result beat for one cycle; a taken pixel passes
//   through 8 code search stages per lane plus the merging register;
//   results leave in input order, one per pixel, up to one per cycle
//   the receiver cannot stall, each beat must be taken in its cycle
//   config channel: i_cfg_valid with i_cfg_index and i_cfg_data, o_cfg_ready always
//   high; index 0 is the frame width, index 1 the frame height, others are dropped;
//   write only while no pixel is in flight
//   out of frame pixels give in_bounds low with zero address and color codes
//   reset: synchronous, active low; empties the pipeline and sets the frame to
//   640 by 480
`default_nettype none

module gamma_encode_rgba_pixel_writer #(
    parameter int MAX_DIM       = gerpw_pkg::MAX_DIM_DEF,
    parameter int FRACTION_BITS = gerpw_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [gerpw_pkg::PIX_W-1:0]     i_pixel_column,
    input  wire logic [gerpw_pkg::PIX_W-1:0]     i_pixel_row,
    input  wire logic [gerpw_pkg::VAL_W-1:0]     i_red_linear,
    input  wire logic [gerpw_pkg::VAL_W-1:0]     i_green_linear,
    input  wire logic [gerpw_pkg::VAL_W-1:0]     i_blue_linear,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [gerpw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [gerpw_pkg::DIM_W-1:0]     i_cfg_data,
    output logic                                 o_valid,
    output logic                                 o_in_bounds,
    output logic      [gerpw_pkg::ADDR_W-1:0]    o_byte_address,
    output logic      [gerpw_pkg::CODE_W-1:0]    o_red_code,
    output logic      [gerpw_pkg::CODE_W-1:0]    o_green_code,
    output logic      [gerpw_pkg::CODE_W-1:0]    o_blue_code,
    output logic      [gerpw_pkg::CODE_W-1:0]    o_alpha_code
);
    import gerpw_pkg::*;

    localparam int LATENCY = LANE_STAGES + 1;

    logic [DIM_W-1:0]       r_frame_width;
    logic [DIM_W-1:0]       r_frame_height;
    logic [DIM_W-1:0]       width_sat;
    logic [DIM_W-1:0]       height_sat;
    logic                   accept;
    logic [LANE_STAGES-1:0] r_vld;
    logic [VAL_W-1:0]       lane_in  [3];
    logic [CODE_W-1:0]      lane_out [3];
    t_addr_beat             addr_beat;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // dimensions above the supported maximum saturate
    always_comb begin
        width_sat  = (32'(r_frame_width) > 32'(MAX_DIM))  ? DIM_W'(MAX_DIM) : r_frame_width;
        height_sat = (32'(r_frame_height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_frame_height;
    end

    assign lane_in[0] = i_red_linear;
    assign lane_in[1] = i_green_linear;
    assign lane_in[2] = i_blue_linear;

    for (genvar l = 0; l < 3; l++) begin : g_lane
        gerpw_lane #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_value (lane_in[l]),
            .o_code  (lane_out[l])
        );
    end

    gerpw_addr u_addr (
        .i_clk          (i_clk),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .i_width        (width_sat),
        .i_height       (height_sat),
        .o_beat         (addr_beat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[LANE_STAGES-2:0], accept};
            o_valid <= r_vld[LANE_STAGES-1];
        end
    end

    // merge: out of frame beats carry zeros
    always_ff @(posedge i_clk) begin
        o_in_bounds    <= addr_beat.in_bounds;
        o_byte_address <= addr_beat.in_bounds ? addr_beat.byte_address : '0;
        o_red_code     <= addr_beat.in_bounds ? lane_out[0] : '0;
        o_green_code   <= addr_beat.in_bounds ? lane_out[1] : '0;
        o_blue_code    <= addr_beat.in_bounds ? lane_out[2] : '0;
    end

    assign o_alpha_code = CODE_W'(CODE_MAX);

    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result beat without a pixel beat");

    a_addr_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_bounds |-> o_byte_address[1:0] == 2'b00)
        else $error("byte address not pixel aligned");

    a_zero_when_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_bounds |-> o_byte_address == '0 && o_red_code == '0
            && o_green_code == '0 && o_blue_code == '0)
        else $error("out of frame beat carries data");

endmodule

`default_nettype wire

### bench/tb_gamma_encode_rgba_pixel_writer.sv
// tb_gamma_encode_rgba_pixel_writer: self-checking bench for the gamma encode rgba pixel writer,
// predicting each frame-store write and comparing it field by field across several frame sizes
// depends on gerpw_pkg and gamma_encode_rgba_pixel_writer
`timescale 1ns / 1ps

module tb_gamma_encode_rgba_pixel_writer;

    import gerpw_pkg::*;

    localparam int          CYCLE_LIMIT      = 200000;
    localparam int          TAIL_CYCLES      = 20;
    localparam int unsigned FRAME_DIM_LIMIT  = MAX_DIM_DEF;
    localparam int unsigned UNITY            = 1 << FRACTION_BITS_DEF;
    localparam int unsigned BYTES_PER_PIXEL  = 4;
    localparam int          BIG_BITS         = 192;
    localparam int unsigned FIRST_UNUSED_REG = 2;

    typedef struct packed {
        logic [PIX_W-1:0] column;
        logic [PIX_W-1:0] row;
        logic [VAL_W-1:0] red;
        logic [VAL_W-1:0] green;
        logic [VAL_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic              in_bounds;
        logic [ADDR_W-1:0] byte_address;
        logic [CODE_W-1:0] red;
        logic [CODE_W-1:0] green;
        logic [CODE_W-1:0] blue;
        logic [CODE_W-1:0] alpha;
    } t_store_write;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic [PIX_W-1:0]     i_pixel_column = '0;
    logic [PIX_W-1:0]     i_pixel_row    = '0;
    logic [VAL_W-1:0]     i_red_linear   = '0;
    logic [VAL_W-1:0]     i_green_linear = '0;
    logic [VAL_W-1:0]     i_blue_linear  = '0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [DIM_W-1:0]     i_cfg_data     = '0;
    logic                 busy;
    logic                 o_cfg_ready;
    logic                 o_valid;
    logic                 o_in_bounds;
    logic [ADDR_W-1:0]    o_byte_address;
    logic [CODE_W-1:0]    o_red_code;
    logic [CODE_W-1:0]    o_green_code;
    logic [CODE_W-1:0]    o_blue_code;
    logic [CODE_W-1:0]    o_alpha_code;

    t_pixel       pixel_backlog[$];
    t_store_write pending_writes[$];
    t_pixel       pixel_on_port    = '0;
    logic [DIM_W-1:0] frame_width_q  = WIDTH_RESET;
    logic [DIM_W-1:0] frame_height_q = HEIGHT_RESET;
    int unsigned  sender_idle_pct  = 0;
    int unsigned  error_count      = 0;
    int unsigned  n_accepted       = 0;
    int unsigned  n_inside         = 0;
    int unsigned  n_frame_sizes    = 1;
    int unsigned  cycle_count      = 0;

    gamma_encode_rgba_pixel_writer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .i_red_linear   (i_red_linear),
        .i_green_linear (i_green_linear),
        .i_blue_linear  (i_blue_linear),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_in_bounds    (o_in_bounds),
        .o_byte_address (o_byte_address),
        .o_red_code     (o_red_code),
        .o_green_code   (o_green_code),
        .o_blue_code    (o_blue_code),
        .o_alpha_code   (o_alpha_code)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] dim);
        return (dim > FRAME_DIM_LIMIT) ? FRAME_DIM_LIMIT : int'(dim);
    endfunction

    // largest code c with v^5 * 255^11 >= c^11 * 2^(5*frac), searched over c
    function automatic logic [CODE_W-1:0] gamma_code(input logic [VAL_W-1:0] v);
        logic [BIG_BITS-1:0] lhs;
        logic [BIG_BITS-1:0] rhs;
        int lo;
        int hi;
        int mid;
        lhs = BIG_BITS'(v);
        for (int i = 0; i < 4; i++) begin
            lhs = lhs * BIG_BITS'(v);
        end
        for (int i = 0; i < 11; i++) begin
            lhs = lhs * BIG_BITS'(CODE_MAX);
        end
        lo = 0;
        hi = CODE_MAX;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            rhs = BIG_BITS'(mid);
            for (int i = 0; i < 10; i++) begin
                rhs = rhs * BIG_BITS'(mid);
            end
            rhs = rhs << (5 * FRACTION_BITS_DEF);
            if (lhs >= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return CODE_W'(lo);
    endfunction

    function automatic t_store_write predict_store_write(input t_pixel p);
        t_store_write wr;
        int unsigned  fw;
        int unsigned  fh;
        int unsigned  flipped;
        fw = clamp_dim(frame_width_q);
        fh = clamp_dim(frame_height_q);
        wr = '0;
        wr.alpha = CODE_W'(CODE_MAX);
        if (p.column < fw && p.row < fh) begin
            flipped         = fh - 1 - p.row;
            wr.in_bounds    = 1'b1;
            wr.byte_address = ADDR_W'((flipped * fw + p.column) * BYTES_PER_PIXEL);
            wr.red          = gamma_code(p.red);
            wr.green        = gamma_code(p.green);
            wr.blue         = gamma_code(p.blue);
        end
        return wr;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // driver: holds each pixel until taken, then predicts its write
    always @(posedge i_clk) begin
        t_pixel       pix;
        t_store_write wr;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                wr = predict_store_write(pixel_on_port);
                pending_writes.push_back(wr);
                n_accepted++;
                if (wr.in_bounds) begin
                    n_inside++;
                end
            end
            if (!start || !busy) begin
                if (pixel_backlog.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
                    pix = pixel_backlog.pop_front();
                    pixel_on_port  <= pix;
                    i_pixel_column <= pix.column;
                    i_pixel_row    <= pix.row;
                    i_red_linear   <= pix.red;
                    i_green_linear <= pix.green;
                    i_blue_linear  <= pix.blue;
                    start          <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every result beat against the oldest predicted write
    always @(posedge i_clk) begin
        t_store_write wr;
        if (i_rst_n && o_valid) begin
            if (pending_writes.size() == 0) begin
                $display("%0t unexpected result beat: expected none, got address %0d",
                         $time, o_byte_address);
                error_count++;
            end else begin
                wr = pending_writes.pop_front();
                check_field("in_bounds", wr.in_bounds, o_in_bounds);
                check_field("byte_address", wr.byte_address, o_byte_address);
                check_field("red_code", wr.red, o_red_code);
                check_field("green_code", wr.green, o_green_code);
                check_field("blue_code", wr.blue, o_blue_code);
                check_field("alpha_code", wr.alpha, o_alpha_code);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_pixel(input int unsigned col, input int unsigned row,
                              input int unsigned r, input int unsigned g, input int unsigned b);
        t_pixel pix;
        pix.column = PIX_W'(col);
        pix.row    = PIX_W'(row);
        pix.red    = VAL_W'(r);
        pix.green  = VAL_W'(g);
        pix.blue   = VAL_W'(b);
        pixel_backlog.push_back(pix);
    endtask

    function automatic int unsigned random_level();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 35) begin
            return $urandom_range(2 ** VAL_W - 1, 0);
        end else if (roll < 70) begin
            return $urandom_range(UNITY, 0);
        end else if (roll < 85) begin
            // dark end, where codes step fastest
            return $urandom_range(300, 0);
        end else begin
            return $urandom_range(UNITY + 256, UNITY - 256);
        end
    endfunction

    function automatic int unsigned random_coord(input int unsigned dim);
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 75 && dim != 0) begin
            return $urandom_range(dim - 1, 0);
        end else if (roll < 85) begin
            return dim - $urandom_range(1, 0);
        end else begin
            return $urandom_range(2 ** PIX_W - 1, 0);
        end
    endfunction

    task automatic push_random_pixels(input int n);
        repeat (n) begin
            push_pixel(random_coord(clamp_dim(frame_width_q)),
                       random_coord(clamp_dim(frame_height_q)),
                       random_level(), random_level(), random_level());
        end
    endtask

    task automatic push_frame_corners();
        int unsigned fw;
        int unsigned fh;
        fw = clamp_dim(frame_width_q);
        fh = clamp_dim(frame_height_q);
        push_pixel(0, 0, random_level(), random_level(), random_level());
        push_pixel(fw - 1, fh - 1, random_level(), random_level(), random_level());
        push_pixel(fw, 0, random_level(), random_level(), random_level());
        push_pixel(0, fh, random_level(), random_level(), random_level());
    endtask

    // leaves valid high; the caller lowers it after its last beat
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_FRAME_WIDTH) begin
            frame_width_q = data;
        end else if (idx == REG_FRAME_HEIGHT) begin
            frame_height_q = data;
        end
    endtask

    task automatic set_frame(input int unsigned fw, input int unsigned fh);
        write_reg(REG_FRAME_WIDTH, DIM_W'(fw));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(fh));
        i_cfg_valid <= 1'b0;
        n_frame_sizes++;
    endtask

    task automatic wait_drained();
        while (pixel_backlog.size() != 0 || start || pending_writes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int n);
        sender_idle_pct = idle_pct;
        push_frame_corners();
        push_random_pixels(n);
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset frame size, extremes of every field
        push_pixel(0, 0, 0, 0, 0);
        push_pixel(639, 479, UNITY, 2 ** VAL_W - 1, UNITY - 1);
        push_pixel(639, 0, 1, 2, 3);
        push_pixel(0, 479, 2 ** VAL_W - 1, 0, UNITY / 2);
        push_pixel(640, 0, 100, 200, 300);
        push_pixel(0, 480, 400, 500, 600);
        push_pixel(2 ** PIX_W - 1, 2 ** PIX_W - 1, 2 ** VAL_W - 1, 2 ** VAL_W - 1,
                   2 ** VAL_W - 1);
        push_pixel(320, 240, 13, 14, 15);
        push_pixel(1, 1, UNITY - 1, UNITY + 1, 0);
        push_pixel(2730, 1365, 16'hAAAA, 16'h5555, 16'h0F0F);
        push_pixel(341, 170, 16'h5555, 16'hAAAA, 16'hF0F0);
        run_phase(0, 150);

        set_frame(1, 1);
        run_phase(77, 170);

        set_frame(FRAME_DIM_LIMIT, FRAME_DIM_LIMIT);
        run_phase(0, 170);

        // above the limit, saturates
        set_frame(2 ** DIM_W - 1, 2 ** DIM_W - 1);
        run_phase(27, 170);

        set_frame(0, 480);
        run_phase(77, 60);

        set_frame(100, 0);
        run_phase(0, 60);

        set_frame($urandom_range(FRAME_DIM_LIMIT, 1), $urandom_range(FRAME_DIM_LIMIT, 1));
        @(posedge i_clk);
        // writes to unused indexes must leave the frame size alone
        write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, FIRST_UNUSED_REG)),
                  DIM_W'($urandom_range(2 ** DIM_W - 1, 0)));
        write_reg('1, '0);
        i_cfg_valid <= 1'b0;
        run_phase(27, 200);

        set_frame($urandom_range(2 ** DIM_W - 1, 1), $urandom_range(2 ** DIM_W - 1, 1));
        run_phase(77, 200);

        set_frame(FRAME_DIM_LIMIT + 1, FRAME_DIM_LIMIT - 1);
        run_phase(0, 170);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d pixels (%0d inside the frame, %0d outside) over %0d frame sizes",
                 n_accepted, n_inside, n_accepted - n_inside, n_frame_sizes);
        $display("mismatches: %0d", error_count);
        if (error_count == 0 && pending_writes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
